>>> hw/rtl/rrq_pkg.sv
// Shared constants and types of the round-robin queue with removal.
package rrq_pkg;

  localparam int unsigned CMD_BITS     = 2;
  localparam int unsigned STATUS_BITS  = 2;
  localparam int unsigned NODE_ID_BITS = 16;

  localparam logic [CMD_BITS-1:0] CMD_ADD  = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_DEL  = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_NEXT = 2'd2;

  localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY     = 2'd2;
  localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 2'd3;

  // Control broadcast from the top level to every cell.
  typedef struct packed {
    logic capture;  // an incoming word is compared against the held slots
    logic add_en;   // the add position takes the stored identifier
    logic del_en;   // cells up to the rearmost match take their neighbor's slot
  } cell_ctrl_t;

endpackage

>>> hw/rtl/rrq_cell.sv
// One slot cell of the queue: holds an identifier, compares it and shifts toward the rear.
module rrq_cell #(
  parameter int unsigned DEPTH   = 16,
  parameter int unsigned ID_BITS = 16,
  parameter int unsigned IDX     = 0
) (
  input  logic                         clk_i,
  input  rrq_pkg::cell_ctrl_t          ctrl_i,
  input  logic [ID_BITS-1:0]           cmp_id_i,
  input  logic [ID_BITS-1:0]           wr_id_i,
  input  logic [$clog2(DEPTH)-1:0]     add_pos_i,
  input  logic [$clog2(DEPTH)-1:0]     front_i,
  input  logic [$clog2(DEPTH+1)-1:0]   count_i,
  input  logic [ID_BITS-1:0]           prev_slot_i,
  input  logic                         su_i,
  input  logic                         sl_i,
  input  logic                         low_any_i,
  output logic [ID_BITS-1:0]           slot_o,
  output logic                         su_o,
  output logic                         sl_o
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [IW-1:0] IDX_V = IW'(IDX);

  logic [ID_BITS-1:0] slot_q, slot_d;
  logic               match_q, match_d;
  logic [CW-1:0]      ring_pos;
  logic               held;
  logic               below_front;
  logic               want;
  logic               shift;

  // Distance from the front in queue order; the cell is held when it lies inside the count.
  always_comb begin
    below_front = IDX_V < front_i;
    if (below_front) begin
      ring_pos = CW'(IDX + DEPTH) - CW'(front_i);
    end else begin
      ring_pos = CW'(IDX) - CW'(front_i);
    end
    held = ring_pos < count_i;
  end

  // Suffix chains: one over all matches, one over matches in the wrapped part below the front.
  assign su_o = su_i | match_q;
  assign sl_o = sl_i | (match_q & below_front);

  // A cell shifts when some match lies at or beyond it toward the rear.
  assign want  = below_front ? sl_o : (su_o | low_any_i);
  assign shift = ctrl_i.del_en && held && (IDX_V != front_i) && want;

  always_comb begin
    match_d = match_q;
    if (ctrl_i.capture) begin
      match_d = held && (slot_q == cmp_id_i);
    end
    slot_d = slot_q;
    if (ctrl_i.add_en && (add_pos_i == IDX_V)) begin
      slot_d = wr_id_i;
    end else if (shift) begin
      slot_d = prev_slot_i;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q  <= slot_d;
    match_q <= match_d;
  end

  assign slot_o = slot_q;

endmodule

>>> hw/rtl/round_robin_queue_with_removal.sv
// Top level of the round-robin queue with removal: control, pointers and the cell row.
//
// A circular queue of node identifiers held in a row of slot cells.
// Input channel (in_valid_i/in_ready_o) carries one word: command_i and
// node_id_i. Commands are add (append at the rear), delete (remove the
// match nearest the rear, shifting earlier entries one slot rearward) and
// fetch next (return the entry under the round-robin pivot and advance it).
// Output channel (out_valid_o/out_ready_i) returns one word per command:
// status_o, next_id_o and next_valid_o.
// An accepted word is compared against every cell and the match flags are
// registered; the suffix chain and shift then run across the cell row and
// the result is registered in the output register. A new word is taken only
// after the current one has finished its suffix chain and shift, so words
// are not overlapped.
// When the receiver stalls, the finished word waits in the output register
// and the following word holds in the compare stage until the output
// frees up. Reset empties the queue and clears all pointers; slot contents
// are not cleared and need no clearing pass.
module round_robin_queue_with_removal #(
  parameter int unsigned DEPTH   = 16,
  parameter int unsigned ID_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [rrq_pkg::CMD_BITS-1:0]         command_i,
  input  logic [rrq_pkg::NODE_ID_BITS-1:0]     node_id_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [rrq_pkg::STATUS_BITS-1:0]      status_o,
  output logic [rrq_pkg::NODE_ID_BITS-1:0]     next_id_o,
  output logic                                 next_valid_o
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned NB = rrq_pkg::NODE_ID_BITS;

  logic                            busy_q, busy_d;
  logic [rrq_pkg::CMD_BITS-1:0]    cmd_q, cmd_d;
  logic [ID_BITS-1:0]              id_q, id_d;
  logic [IW-1:0]                   front_q, front_d;
  logic [IW-1:0]                   rear_q, rear_d;
  logic [IW-1:0]                   pivot_q, pivot_d;
  logic [CW-1:0]                   count_q, count_d;
  logic                            out_valid_q, out_valid_d;
  logic [rrq_pkg::STATUS_BITS-1:0] status_q, status_d;
  logic [NB-1:0]                   next_id_q, next_id_d;
  logic                            next_valid_q, next_valid_d;

  logic                 accept;
  logic                 exec;
  logic [ID_BITS-1:0]   in_id;
  logic [IW-1:0]        add_pos;
  logic                 is_empty;
  logic                 is_full;
  logic                 found;
  logic [NB-1:0]        pivot_id;
  rrq_pkg::cell_ctrl_t  ctrl;

  logic [ID_BITS-1:0]   slot_w [DEPTH];
  logic [DEPTH:0]       su_w;
  logic [DEPTH:0]       sl_w;

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] idx);
    logic [IW-1:0] res;
    if (idx == IW'(DEPTH - 1)) begin
      res = '0;
    end else begin
      res = idx + 1'b1;
    end
    return res;
  endfunction

  // Identifiers are taken in their low ID_BITS bits and returned in 16 bits.
  if (ID_BITS <= NB) begin : g_narrow
    assign in_id = node_id_i[ID_BITS-1:0];
    if (ID_BITS < NB) begin : g_ext
      assign pivot_id = {{(NB - ID_BITS){1'b0}}, slot_w[pivot_q]};
    end else begin : g_eq
      assign pivot_id = slot_w[pivot_q];
    end
  end else begin : g_wide
    assign in_id    = {{(ID_BITS - NB){1'b0}}, node_id_i};
    assign pivot_id = slot_w[pivot_q][NB-1:0];
  end

  assign in_ready_o = !busy_q;
  assign accept     = in_valid_i && in_ready_o;
  assign exec       = busy_q && (!out_valid_q || out_ready_i);

  assign is_empty = (count_q == '0);
  assign is_full  = (count_q == CW'(DEPTH));
  assign found    = su_w[0];
  assign add_pos  = is_empty ? '0 : wrap_inc(rear_q);

  assign ctrl.capture = accept;
  assign ctrl.add_en  = exec && (cmd_q == rrq_pkg::CMD_ADD) && !is_full;
  assign ctrl.del_en  = exec && (cmd_q == rrq_pkg::CMD_DEL) && !is_empty && found;

  assign su_w[DEPTH] = 1'b0;
  assign sl_w[DEPTH] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    rrq_cell #(
      .DEPTH   (DEPTH),
      .ID_BITS (ID_BITS),
      .IDX     (i)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .cmp_id_i    (in_id),
      .wr_id_i     (id_q),
      .add_pos_i   (add_pos),
      .front_i     (front_q),
      .count_i     (count_q),
      .prev_slot_i (slot_w[(i + DEPTH - 1) % DEPTH]),
      .su_i        (su_w[i+1]),
      .sl_i        (sl_w[i+1]),
      .low_any_i   (sl_w[0]),
      .slot_o      (slot_w[i]),
      .su_o        (su_w[i]),
      .sl_o        (sl_w[i])
    );
  end

  always_comb begin
    busy_d       = busy_q;
    cmd_d        = cmd_q;
    id_d         = id_q;
    front_d      = front_q;
    rear_d       = rear_q;
    pivot_d      = pivot_q;
    count_d      = count_q;
    out_valid_d  = out_valid_q;
    status_d     = status_q;
    next_id_d    = next_id_q;
    next_valid_d = next_valid_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (accept) begin
      busy_d = 1'b1;
      cmd_d  = command_i;
      id_d   = in_id;
    end

    if (exec) begin
      busy_d       = 1'b0;
      out_valid_d  = 1'b1;
      status_d     = rrq_pkg::ST_OK;
      next_id_d    = '0;
      next_valid_d = 1'b0;
      case (cmd_q)
        rrq_pkg::CMD_ADD: begin
          if (is_full) begin
            status_d = rrq_pkg::ST_FULL;
          end else begin
            if (is_empty) begin
              front_d = '0;
              pivot_d = '0;
            end
            rear_d  = add_pos;
            count_d = count_q + 1'b1;
          end
        end
        rrq_pkg::CMD_DEL: begin
          if (is_empty) begin
            status_d = rrq_pkg::ST_EMPTY;
          end else if (!found) begin
            status_d = rrq_pkg::ST_NOT_FOUND;
          end else if (count_q == CW'(1)) begin
            count_d = '0;
            front_d = '0;
            rear_d  = '0;
            pivot_d = '0;
          end else begin
            // The front slot is vacated, so a pivot sitting there moves with it.
            if (pivot_q == front_q) begin
              pivot_d = wrap_inc(pivot_q);
            end
            front_d = wrap_inc(front_q);
            count_d = count_q - 1'b1;
          end
        end
        rrq_pkg::CMD_NEXT: begin
          if (is_empty) begin
            status_d = rrq_pkg::ST_EMPTY;
          end else begin
            next_id_d    = pivot_id;
            next_valid_d = 1'b1;
            pivot_d      = (pivot_q == rear_q) ? front_q : wrap_inc(pivot_q);
          end
        end
        default: begin
          status_d = rrq_pkg::ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      front_q     <= '0;
      rear_q      <= '0;
      pivot_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      front_q     <= front_d;
      rear_q      <= rear_d;
      pivot_q     <= pivot_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    id_q         <= id_d;
    status_q     <= status_d;
    next_id_q    <= next_id_d;
    next_valid_q <= next_valid_d;
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign next_id_o    = next_id_q;
  assign next_valid_o = next_valid_q;

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the round-robin queue with removal.
module tb_top;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned ID_BITS     = 16;
  localparam int unsigned IDLE_LIMIT  = 2000;
  localparam int unsigned RANDOM_CMDS = 700;
  localparam int unsigned CB          = rrq_pkg::CMD_BITS;
  localparam int unsigned SB          = rrq_pkg::STATUS_BITS;
  localparam int unsigned NB          = rrq_pkg::NODE_ID_BITS;
  localparam logic [CB-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [SB-1:0] status;
    logic [NB-1:0] next_id;
    logic          next_valid;
  } rr_result_t;

  typedef struct {
    logic [CB-1:0] cmd;
    logic [NB-1:0] id;
    bit            drain_first;
  } cmd_word_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid_i = 1'b0;
  logic          in_ready_o;
  logic [CB-1:0] command_i = '0;
  logic [NB-1:0] node_id_i = '0;
  logic          out_valid_o;
  logic          out_ready_i = 1'b0;
  logic [SB-1:0] status_o;
  logic [NB-1:0] next_id_o;
  logic          next_valid_o;

  round_robin_queue_with_removal #(
    .DEPTH  (DEPTH),
    .ID_BITS(ID_BITS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .node_id_i   (node_id_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .next_id_o   (next_id_o),
    .next_valid_o(next_valid_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow copy of the ring of node identifiers.
  logic [ID_BITS-1:0] ring [DEPTH];
  logic [3:0]         ring_front = '0;
  logic [3:0]         ring_rear = '0;
  logic [3:0]         rr_pivot = '0;
  int unsigned        ring_count = 0;

  cmd_word_t   cmd_backlog[$];
  rr_result_t  expected_results[$];
  logic [15:0] id_pool [8];
  int unsigned words_sent = 0;
  int unsigned results_seen = 0;
  int unsigned total_words = 0;
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  int unsigned status_tally [4] = '{0, 0, 0, 0};
  int unsigned fetch_hits = 0;
  bit          in_taken = 1'b0;

  // Applies one command to the shadow ring and returns the result word it gives.
  function automatic rr_result_t apply_command(input logic [CB-1:0] cmd,
                                               input logic [NB-1:0] id);
    rr_result_t  res;
    logic [3:0]  idx;
    logic [3:0]  hit;
    bit          found;
    res.status     = rrq_pkg::ST_OK;
    res.next_id    = '0;
    res.next_valid = 1'b0;
    idx            = '0;
    hit            = '0;
    found          = 1'b0;
    case (cmd)
      rrq_pkg::CMD_ADD: begin
        if (ring_count == DEPTH) begin
          res.status = rrq_pkg::ST_FULL;
        end else begin
          if (ring_count == 0) begin
            ring_front = '0;
            ring_rear  = '0;
            rr_pivot   = '0;
          end else begin
            ring_rear = ring_rear + 1'b1;
          end
          ring[ring_rear] = id;
          ring_count++;
        end
      end
      rrq_pkg::CMD_DEL: begin
        if (ring_count == 0) begin
          res.status = rrq_pkg::ST_EMPTY;
        end else begin
          // The last match in front-to-rear order wins, so duplicates lose the rearmost.
          idx = ring_front;
          for (int unsigned k = 0; k < ring_count; k++) begin
            if (ring[idx] == id) begin
              hit   = idx;
              found = 1'b1;
            end
            idx = idx + 1'b1;
          end
          if (!found) begin
            res.status = rrq_pkg::ST_NOT_FOUND;
          end else if (ring_count == 1) begin
            ring_count = 0;
            ring_front = '0;
            ring_rear  = '0;
            rr_pivot   = '0;
          end else begin
            while (hit != ring_front) begin
              ring[hit] = ring[hit - 1'b1];
              hit       = hit - 1'b1;
            end
            if (rr_pivot == ring_front) rr_pivot = rr_pivot + 1'b1;
            ring_front = ring_front + 1'b1;
            ring_count--;
          end
        end
      end
      rrq_pkg::CMD_NEXT: begin
        if (ring_count == 0) begin
          res.status = rrq_pkg::ST_EMPTY;
        end else begin
          res.next_id    = ring[rr_pivot];
          res.next_valid = 1'b1;
          if (rr_pivot == ring_rear) rr_pivot = ring_front;
          else rr_pivot = rr_pivot + 1'b1;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic logic [15:0] pick_id();
    if ($urandom_range(0, 4) == 0) return 16'($urandom_range(0, 16'hFFFF));
    return id_pool[$urandom_range(0, 7)];
  endfunction

  task automatic queue_word(input logic [CB-1:0] cmd, input logic [15:0] id,
                            input bit drain_first = 1'b0);
    cmd_word_t w;
    w.cmd         = cmd;
    w.id          = id;
    w.drain_first = drain_first;
    cmd_backlog.push_back(w);
  endtask

  // Sender: bursts of words separated by random gaps.
  int unsigned burst_left = 8;
  int unsigned gap_left = 0;

  always @(negedge clk_i) begin
    bit        offer;
    cmd_word_t head;
    if (rst_ni) begin
      offer = in_valid_i && !in_taken;
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_backlog.size() > 0 &&
                     !(cmd_backlog[0].drain_first && expected_results.size() != 0)) begin
          head = cmd_backlog.pop_front();
          command_i <= head.cmd;
          node_id_i <= head.id;
          offer = 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
      in_valid_i <= offer;
    end
  end

  // Receiver: its own stall pattern plus one long hold-off that backs the block up.
  int unsigned stall_clock = 0;
  int unsigned stall_mode = 0;
  int unsigned holdoff_left = 0;
  bit          holdoff_done = 1'b0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      stall_clock++;
      if (stall_clock % 48 == 0) stall_mode = $urandom_range(0, 2);
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_ready_i <= 1'b0;
      end else if (!holdoff_done && results_seen >= 200) begin
        holdoff_done = 1'b1;
        holdoff_left = 150;
        out_ready_i <= 1'b0;
      end else begin
        case (stall_mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(0, 1));
          default: out_ready_i <= (stall_clock % 3 == 0);
        endcase
      end
    end
  end

  // Monitor: predicts on each accepted command word and checks each result word.
  always @(posedge clk_i) begin
    rr_result_t want;
    bit         fired;
    if (rst_ni) begin
      fired = 1'b0;
      in_taken <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) begin
        expected_results.push_back(apply_command(command_i, node_id_i));
        words_sent++;
        fired = 1'b1;
      end
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        fired = 1'b1;
        if (expected_results.size() == 0) begin
          $error("unexpected result word: status %0d next_id %0h", status_o, next_id_o);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            errors++;
          end
          if (next_id_o !== want.next_id) begin
            $error("next_id: expected %0h, got %0h", want.next_id, next_id_o);
            errors++;
          end
          if (next_valid_o !== want.next_valid) begin
            $error("next_valid: expected %0d, got %0d", want.next_valid, next_valid_o);
            errors++;
          end
          status_tally[want.status]++;
          if (want.next_valid) fetch_hits++;
        end
      end
      idle_cycles = fired ? 0 : idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("Timeout: no word moved for %0d cycles", IDLE_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    int unsigned made;
    int unsigned seg_len;
    int unsigned add_pct;
    int unsigned del_pct;
    int unsigned roll;
    made = 0;
    for (int i = 0; i < 8; i++) id_pool[i] = 16'($urandom_range(0, 16'hFFFF));
    id_pool[0] = 16'h0000;
    id_pool[1] = 16'hFFFF;

    // Directed: the empty cases, the unused command, removal of the last entry,
    // duplicates, a miss, the front removed under the pivot, and a fill to full.
    queue_word(rrq_pkg::CMD_NEXT, 16'h0000);
    queue_word(rrq_pkg::CMD_DEL, 16'h0005);
    queue_word(CMD_UNUSED, 16'hFFFF);
    queue_word(rrq_pkg::CMD_ADD, 16'h0000);
    queue_word(rrq_pkg::CMD_DEL, 16'h0000);
    queue_word(rrq_pkg::CMD_ADD, 16'hFFFF);
    queue_word(rrq_pkg::CMD_ADD, 16'h0001);
    queue_word(rrq_pkg::CMD_ADD, 16'hFFFF);
    queue_word(rrq_pkg::CMD_NEXT, 16'h0000);
    queue_word(rrq_pkg::CMD_DEL, 16'h0009);
    queue_word(rrq_pkg::CMD_DEL, 16'hFFFF);
    queue_word(rrq_pkg::CMD_DEL, 16'hFFFF);
    queue_word(rrq_pkg::CMD_DEL, 16'h0001);
    for (int i = 0; i < 17; i++) queue_word(rrq_pkg::CMD_ADD, 16'(1 << (i % 16)));
    queue_word(rrq_pkg::CMD_DEL, 16'h0080);
    queue_word(rrq_pkg::CMD_NEXT, 16'h0000);

    // Random: segments that lean toward filling, draining or a mix.
    while (made < RANDOM_CMDS) begin
      seg_len = $urandom_range(15, 60);
      case ($urandom_range(0, 2))
        0: begin add_pct = 65; del_pct = 20; end
        1: begin add_pct = 15; del_pct = 60; end
        default: begin add_pct = 35; del_pct = 35; end
      endcase
      for (int unsigned n = 0; n < seg_len && made < RANDOM_CMDS; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < add_pct)
          queue_word(rrq_pkg::CMD_ADD, pick_id(), made == 0 || made == 350);
        else if (roll < add_pct + del_pct)
          queue_word(rrq_pkg::CMD_DEL, pick_id(), made == 0 || made == 350);
        else if (roll < 98)
          queue_word(rrq_pkg::CMD_NEXT, 16'($urandom_range(0, 16'hFFFF)),
                     made == 0 || made == 350);
        else queue_word(CMD_UNUSED, pick_id(), made == 0 || made == 350);
        made++;
      end
    end
    total_words = cmd_backlog.size();

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    while (words_sent < total_words) @(negedge clk_i);
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);

    $display("Checked %0d result words: %0d ok, %0d full, %0d empty, %0d not found.",
             results_seen, status_tally[0], status_tally[1], status_tally[2], status_tally[3]);
    $display("%0d round-robin fetches returned a queued identifier.", fetch_hits);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
